FILE: design/rfb_pkg.sv
// Shared types, request codes and widths for the RGB fade and blink controller.
package rfb_pkg;

    localparam int NUM_CH   = 3;
    localparam int CH_W     = 2;
    localparam int LVL_W    = 8;
    localparam int STEP_W   = 9;
    localparam int TICKS_W  = 13;
    localparam int DIV_BITS = LVL_W;
    localparam int BIT_W    = 3;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    localparam logic [TICKS_W-1:0] FADE_TICKS_RST = 13'd100;

    // Register index taken from paddr[2]
    localparam logic CFG_FADE_TICKS   = 1'b0;
    localparam logic CFG_COMMON_ANODE = 1'b1;

    typedef enum logic [1:0] {
        REQ_TICK  = 2'd0,
        REQ_SET   = 2'd1,
        REQ_FADE  = 2'd2,
        REQ_BLINK = 2'd3
    } t_req;

    typedef logic [LVL_W-1:0]         t_level;
    typedef t_level [NUM_CH-1:0]      t_color;
    typedef logic signed [STEP_W-1:0] t_step;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic            capture;
        logic            exec;
        logic            div_load;
        logic            div_step;
        logic            store;
        logic [CH_W-1:0] ch;
        logic            load_out;
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic aim;
    } t_stat;

endpackage

FILE: design/rfb_ctrl.sv
// Controller state machine: sequences capture, update, step division and result load.
module rfb_ctrl
    import rfb_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_stall,
    output logic  o_valid,
    input  logic  i_stall,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_EXEC   = 6'b000010,
        S_DLOAD  = 6'b000100,
        S_DSTEP  = 6'b001000,
        S_DSTORE = 6'b010000,
        S_DONE   = 6'b100000
    } t_state;

    t_state           r_state, n_state;
    logic [CH_W-1:0]  r_ch, n_ch;
    logic [BIT_W-1:0] r_bit, n_bit;
    logic             r_out_valid, n_out_valid;

    // Next state and commands
    always_comb begin
        n_state       = r_state;
        n_ch          = r_ch;
        n_bit         = r_bit;
        o_cmd         = '0;
        o_cmd.ch      = r_ch;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                if (i_stat.aim) begin
                    n_ch    = '0;
                    n_state = S_DLOAD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DLOAD: begin
                o_cmd.div_load = 1'b1;
                n_bit          = '0;
                n_state        = S_DSTEP;
            end
            S_DSTEP: begin
                o_cmd.div_step = 1'b1;
                n_bit          = r_bit + 1'b1;
                if (r_bit == BIT_W'(DIV_BITS - 1)) begin
                    n_state = S_DSTORE;
                end
            end
            S_DSTORE: begin
                o_cmd.store = 1'b1;
                if (r_ch == CH_W'(NUM_CH - 1)) begin
                    n_state = S_DONE;
                end else begin
                    n_ch    = r_ch + 1'b1;
                    n_state = S_DLOAD;
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_stall) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold the result valid until taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ch        <= '0;
            r_bit       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ch        <= n_ch;
            r_bit       <= n_bit;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;

endmodule

FILE: design/rfb_dp.sv
// Datapath: level state, serial step divider and output register.
module rfb_dp
    import rfb_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [1:0]         i_req_type,
    input  logic [LVL_W-1:0]   i_red,
    input  logic [LVL_W-1:0]   i_green,
    input  logic [LVL_W-1:0]   i_blue,
    input  logic [TICKS_W-1:0] i_fade_ticks,
    input  logic               i_common_anode,
    input  t_cmd               i_cmd,
    output t_stat              o_stat,
    output logic [LVL_W-1:0]   o_drive_red,
    output logic [LVL_W-1:0]   o_drive_green,
    output logic [LVL_W-1:0]   o_drive_blue,
    output logic               o_on_target
);

    // Move one level toward its target without passing it
    function automatic t_level f_step_toward(input t_level tgt, input t_level cur,
                                             input t_step st);
        logic signed [LVL_W+1:0] nxt;
        logic signed [LVL_W+1:0] tgt_s;
        t_level                  res;
        nxt   = $signed({2'b00, cur}) + $signed({st[STEP_W-1], st});
        tgt_s = $signed({2'b00, tgt});
        if (!st[STEP_W-1] && (nxt > tgt_s)) begin
            res = tgt;
        end else if (st[STEP_W-1] && (nxt < tgt_s)) begin
            res = tgt;
        end else begin
            res = nxt[LVL_W-1:0];
        end
        return res;
    endfunction

    t_req   r_req;
    t_color r_col;
    t_color r_cur;
    t_color r_tgt;
    t_color r_blink_col;
    t_step  r_step [NUM_CH];
    logic   r_blinking;

    t_level r_dvd;
    t_level r_rem;
    logic   r_neg;

    t_level r_out_red, r_out_green, r_out_blue;
    logic   r_out_on_target;

    logic               w_at_tgt;
    t_color             w_blink_next;
    t_color             w_aim_col;
    logic               w_aim;
    logic [TICKS_W-1:0] w_div;
    t_level             w_ch_cur, w_ch_tgt;
    logic               w_pos;
    t_level             w_mag;
    logic [LVL_W:0]     w_trial;
    logic               w_ge;
    t_level             w_q;
    t_step              w_new_step;

    assign w_at_tgt = (r_cur == r_tgt);

    // Next blink target: the blink color where a channel is dark, else dark
    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            w_blink_next[c] = (r_cur[c] == '0) ? r_blink_col[c] : '0;
        end
    end

    // Decide whether the item sets a new target, and which
    always_comb begin
        w_aim     = 1'b0;
        w_aim_col = r_col;
        case (r_req)
            REQ_TICK: begin
                w_aim     = w_at_tgt && r_blinking;
                w_aim_col = w_blink_next;
            end
            REQ_SET:   w_aim = 1'b1;
            REQ_FADE:  w_aim = (r_col != r_tgt);
            REQ_BLINK: w_aim = (r_col != r_blink_col);
            default:   w_aim = 1'b0;
        endcase
    end

    assign o_stat.aim = w_aim;

    // Divider operands for the selected channel
    assign w_div    = (i_fade_ticks == '0) ? TICKS_W'(1) : i_fade_ticks;
    assign w_ch_cur = r_cur[i_cmd.ch];
    assign w_ch_tgt = r_tgt[i_cmd.ch];
    assign w_pos    = (w_ch_tgt >= w_ch_cur);
    assign w_mag    = w_pos ? (w_ch_tgt - w_ch_cur) : (w_ch_cur - w_ch_tgt);
    assign w_trial  = {r_rem, r_dvd[LVL_W-1]};
    assign w_ge     = ({{(TICKS_W-LVL_W-1){1'b0}}, w_trial} >= w_div);

    // Signed step; raise a zero quotient to one unit toward the target
    always_comb begin
        w_q = r_dvd;
        if ((r_dvd == '0) && (w_ch_cur != w_ch_tgt)) begin
            w_q = LVL_W'(1);
        end
        w_new_step = r_neg ? t_step'(STEP_W'(0) - {1'b0, w_q}) : t_step'({1'b0, w_q});
    end

    // Level state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur       <= '0;
            r_tgt       <= '0;
            r_blink_col <= '0;
            r_blinking  <= 1'b0;
            for (int c = 0; c < NUM_CH; c++) begin
                r_step[c] <= '0;
            end
        end else begin
            if (i_cmd.exec) begin
                case (r_req)
                    REQ_TICK: begin
                        if (!w_at_tgt) begin
                            for (int c = 0; c < NUM_CH; c++) begin
                                r_cur[c] <= f_step_toward(r_tgt[c], r_cur[c], r_step[c]);
                            end
                        end
                    end
                    REQ_SET: begin
                        r_blinking <= 1'b0;
                        r_cur      <= r_col;
                    end
                    REQ_FADE: begin
                        r_blinking <= 1'b0;
                    end
                    REQ_BLINK: begin
                        r_blinking <= 1'b1;
                        if (w_aim) begin
                            r_blink_col <= r_col;
                        end
                    end
                    default: begin
                        r_blinking <= r_blinking;
                    end
                endcase
                if (w_aim) begin
                    r_tgt <= w_aim_col;
                end
            end
            if (i_cmd.store) begin
                r_step[i_cmd.ch] <= w_new_step;
            end
        end
    end

    // Capture the item, run the restoring divider, load the result
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req <= t_req'(i_req_type);
            r_col <= {i_blue, i_green, i_red};
        end
        if (i_cmd.div_load) begin
            r_rem <= '0;
            r_dvd <= w_mag;
            r_neg <= !w_pos;
        end else if (i_cmd.div_step) begin
            r_rem <= w_ge ? LVL_W'({{(TICKS_W-LVL_W-1){1'b0}}, w_trial} - w_div)
                          : w_trial[LVL_W-1:0];
            r_dvd <= {r_dvd[LVL_W-2:0], w_ge};
        end
        if (i_cmd.load_out) begin
            r_out_red       <= i_common_anode ? ~r_cur[0] : r_cur[0];
            r_out_green     <= i_common_anode ? ~r_cur[1] : r_cur[1];
            r_out_blue      <= i_common_anode ? ~r_cur[2] : r_cur[2];
            r_out_on_target <= w_at_tgt;
        end
    end

    assign o_drive_red   = r_out_red;
    assign o_drive_green = r_out_green;
    assign o_drive_blue  = r_out_blue;
    assign o_on_target   = r_out_on_target;

endmodule

FILE: design/rgb_fade_blink_controller_top.sv
// Top level of the RGB fade and blink controller: register port, controller, datapath.
//
//   channel  direction  handshake           payload
//   in       input      i_valid / o_stall   i_req_type, i_red, i_green, i_blue
//   out      output     o_valid / i_stall   o_drive_red/green/blue, o_on_target
//   cfg      input      psel/penable/pready paddr, pwdata, prdata
//
// An item that sets no new target goes from capture through the update to the result
// load; one that sets a target also runs the shared serial divider (one quotient bit
// per cycle, three channels in turn, each loaded, stepped and stored). Reset is
// synchronous and restores all levels to zero, fade_ticks to 100 and common_anode to 0.
// A stalled result waits in the output register while the next item is taken.
module rgb_fade_blink_controller_top
    import rfb_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_req_type,
    input  logic [LVL_W-1:0]   i_red,
    input  logic [LVL_W-1:0]   i_green,
    input  logic [LVL_W-1:0]   i_blue,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [LVL_W-1:0]   o_drive_red,
    output logic [LVL_W-1:0]   o_drive_green,
    output logic [LVL_W-1:0]   o_drive_blue,
    output logic               o_on_target,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    logic [TICKS_W-1:0] r_fade_ticks;
    logic               r_common_anode;
    logic               w_wr;
    t_cmd               w_cmd;
    t_stat              w_stat;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fade_ticks   <= FADE_TICKS_RST;
            r_common_anode <= 1'b0;
        end else if (w_wr) begin
            if (paddr[2] == CFG_FADE_TICKS) begin
                r_fade_ticks <= pwdata[TICKS_W-1:0];
            end else begin
                r_common_anode <= pwdata[0];
            end
        end
    end

    // Read back
    assign prdata = (paddr[2] == CFG_COMMON_ANODE) ?
                    {{(PDATA_W-1){1'b0}}, r_common_anode} :
                    {{(PDATA_W-TICKS_W){1'b0}}, r_fade_ticks};

    rfb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    rfb_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req_type     (i_req_type),
        .i_red          (i_red),
        .i_green        (i_green),
        .i_blue         (i_blue),
        .i_fade_ticks   (r_fade_ticks),
        .i_common_anode (r_common_anode),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .o_drive_red    (o_drive_red),
        .o_drive_green  (o_drive_green),
        .o_drive_blue   (o_drive_blue),
        .o_on_target    (o_on_target)
    );

    // Busy right after an item is taken
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input not stalled after item accepted");

    // Update only follows a capture
    a_exec_after_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.exec |-> $past(w_cmd.capture))
        else $error("update without captured item");

    // Divider load is followed by a divide step
    a_step_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.div_load |=> w_cmd.div_step)
        else $error("divider loaded but not stepped");

    // Never overwrite a result that is still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_out |-> (!o_valid || !i_stall))
        else $error("pending result overwritten");

endmodule
